// File: src/mctb_pkg.sv
// Shared types and constants for the timer bank.
package mctb_pkg;

  // Fixed widths of the request and response words
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 8;
  localparam int TICKS_W = 16;
  localparam int MASK_W  = 8;

  // Request codes (code 7 is unused and answers with an error)
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC      = 3'd0,
    REQ_FREE       = 3'd1,
    REQ_SET_RELOAD = 3'd2,
    REQ_START_PER  = 3'd3,
    REQ_START_ONE  = 3'd4,
    REQ_STOP       = 3'd5,
    REQ_TICK       = 3'd6
  } req_type_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TICK,
    ST_START,
    ST_DONE
  } state_t;

  // One response word
  typedef struct packed {
    logic              status;
    logic [IDX_W-1:0]  result_index;
    logic [MASK_W-1:0] expired_mask;
  } result_t;

endpackage

// File: src/mctb_if.sv
// Request and response channel interfaces of the timer bank.
interface mctb_req_if;
  logic                           valid;
  logic                           ready;
  logic [mctb_pkg::REQ_W-1:0]     req_type;
  logic [mctb_pkg::IDX_W-1:0]     timer_index;
  logic [mctb_pkg::TICKS_W-1:0]   reload_ticks;

  modport source (output valid, output req_type, output timer_index,
                  output reload_ticks, input ready);
  modport sink   (input valid, input req_type, input timer_index,
                  input reload_ticks, output ready);
endinterface

interface mctb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [mctb_pkg::IDX_W-1:0]    result_index;
  logic [mctb_pkg::MASK_W-1:0]   expired_mask;

  modport source (output valid, output status, output result_index,
                  output expired_mask, input ready);
  modport sink   (input valid, input status, input result_index,
                  input expired_mask, output ready);
endinterface

// File: src/mctb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mctb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mctb_out_stage.sv
// Output register that holds one response word until the sink takes it.
module mctb_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mctb_pkg::result_t data,
  output logic              free,
  mctb_rsp_if.source        rsp
);

  logic              vld;
  mctb_pkg::result_t word;

  // Slot can take a new word when empty or being drained this cycle
  assign free = !vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (rsp.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= data;
    end
  end

  assign rsp.valid        = vld;
  assign rsp.status       = word.status;
  assign rsp.result_index = word.result_index;
  assign rsp.expired_mask = word.expired_mask;

  // A loaded word is presented on the next cycle
  assert property (@(posedge clk) disable iff (rst) load |=> rsp.valid)
    else $error("loaded response word not presented");
  // The slot never takes a word while a stalled one is still held
  assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("response word overwritten while stalled");
  // Word content holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> $stable(word))
    else $error("stalled response word changed");

endmodule

// File: src/multi_channel_timer_bank.sv
// Timer bank top level: request sequencer, flag vectors and counter/reload memories.
//
// A bank of NUM_TIMERS down-counting timers driven by one request word at a
// time. Reload values and counters live in two RAMs with a registered read;
// the allocated, running and one-shot flags are flip-flops. Free, stop,
// set-reload, an unused code and a start on an unallocated timer go straight
// from accept to the done state that stages the response; a start first
// reads the reload value and then writes the counter; an allocate scans the
// allocated flags one timer per cycle; and a tick walks the counter RAM one
// entry per cycle, each entry read and then written back in the next cycle.
// The response then sits in an output register; the next request is taken
// once the sequencer is back to idle, even if that register is still
// waiting on the sink.
// Counters wrap modulo 2**COUNT_WIDTH; only timers 0 to 7 show in the
// expiry mask. Both RAMs need no clearing pass: a never-written reload
// reads as zero through a per-entry valid bit, and a counter is only read
// after a start has written it.
module multi_channel_timer_bank #(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  mctb_req_if.sink   req,
  mctb_rsp_if.source rsp
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [CW-1:0] PTR_LAST = CW'(NUM_TIMERS - 1);
  localparam logic [CW-1:0] PTR_END  = CW'(NUM_TIMERS);

  mctb_pkg::state_t state, state_next;

  logic [NUM_TIMERS-1:0] alloc;
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] one_shot;
  logic [NUM_TIMERS-1:0] rld_vld;

  logic [CW-1:0]  ptr;
  logic [IW-1:0]  ptr_i;
  logic           proc_vld;
  logic [IW-1:0]  proc_idx;
  logic [IW-1:0]  op_idx;
  logic           rld_ok_q;

  logic                          res_status;
  logic [mctb_pkg::IDX_W-1:0]    res_index;
  logic [mctb_pkg::MASK_W-1:0]   mask_q;

  // Request decode
  logic                  acc;
  mctb_pkg::req_type_t   rt;
  logic                  ridx_ok;
  logic [IW-1:0]         ridx;
  logic                  ridx_alloc;

  // Memory ports
  logic [IW-1:0]          rd_addr;
  logic                   rld_we;
  logic [COUNT_WIDTH-1:0] rld_rdata;
  logic [COUNT_WIDTH-1:0] rld_eff;
  logic                   cnt_we;
  logic [IW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  logic              tick_issue;
  logic              tick_hit;
  logic              out_free;
  logic              out_load;
  mctb_pkg::result_t res_word;

  assign acc        = req.valid && req.ready;
  assign rt         = mctb_pkg::req_type_t'(req.req_type);
  assign ridx_ok    = req.timer_index < mctb_pkg::IDX_W'(NUM_TIMERS);
  assign ridx       = req.timer_index[IW-1:0];
  assign ridx_alloc = ridx_ok && alloc[ridx];
  assign ptr_i      = ptr[IW-1:0];

  assign rd_addr    = (state == mctb_pkg::ST_TICK) ? ptr_i : ridx;
  assign rld_eff    = rld_ok_q ? rld_rdata : '0;
  assign cnt_dec    = cnt_rdata - COUNT_WIDTH'(1);
  assign tick_issue = (state == mctb_pkg::ST_TICK) && (ptr != PTR_END);

  // Reload values
  mctb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_rld_ram (
    .clk   (clk),
    .we    (rld_we),
    .waddr (ridx),
    .wdata (COUNT_WIDTH'(req.reload_ticks)),
    .raddr (rd_addr),
    .rdata (rld_rdata)
  );

  // Current counts
  mctb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mctb_pkg::ST_IDLE: begin
        if (acc) begin
          case (rt)
            mctb_pkg::REQ_ALLOC: state_next = mctb_pkg::ST_ALLOC;
            mctb_pkg::REQ_TICK:  state_next = mctb_pkg::ST_TICK;
            mctb_pkg::REQ_START_PER,
            mctb_pkg::REQ_START_ONE:
              state_next = ridx_alloc ? mctb_pkg::ST_START : mctb_pkg::ST_DONE;
            default: state_next = mctb_pkg::ST_DONE;
          endcase
        end
      end
      mctb_pkg::ST_ALLOC: begin
        if (!alloc[ptr_i] || ptr == PTR_LAST) begin
          state_next = mctb_pkg::ST_DONE;
        end
      end
      mctb_pkg::ST_TICK: begin
        if (ptr == PTR_END && proc_vld) begin
          state_next = mctb_pkg::ST_DONE;
        end
      end
      mctb_pkg::ST_START: state_next = mctb_pkg::ST_DONE;
      mctb_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mctb_pkg::ST_IDLE;
        end
      end
      default: state_next = mctb_pkg::ST_IDLE;
    endcase
  end

  // Handshake, memory writes and tick arithmetic
  always_comb begin
    req.ready = 1'b0;
    rld_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = proc_idx;
    cnt_wdata = cnt_dec;
    tick_hit  = 1'b0;
    out_load  = 1'b0;
    case (state)
      mctb_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        rld_we    = acc && (rt == mctb_pkg::REQ_SET_RELOAD) && ridx_alloc;
      end
      mctb_pkg::ST_TICK: begin
        // Write back the entry read on the previous cycle
        if (proc_vld && running[proc_idx]) begin
          cnt_we   = 1'b1;
          tick_hit = (cnt_dec == '0);
          if (tick_hit && !one_shot[proc_idx]) begin
            cnt_wdata = rld_eff;
          end
        end
      end
      mctb_pkg::ST_START: begin
        cnt_we    = 1'b1;
        cnt_waddr = op_idx;
        cnt_wdata = rld_eff;
      end
      mctb_pkg::ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // Sequencer registers, flags and response fields
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mctb_pkg::ST_IDLE;
      alloc    <= '0;
      running  <= '0;
      rld_vld  <= '0;
      proc_vld <= 1'b0;
    end else begin
      state    <= state_next;
      proc_vld <= tick_issue;
      proc_idx <= ptr_i;
      rld_ok_q <= rld_vld[rd_addr];
      case (state)
        mctb_pkg::ST_IDLE: begin
          if (acc) begin
            ptr        <= '0;
            mask_q     <= '0;
            op_idx     <= ridx;
            res_status <= 1'b1;
            res_index  <= '0;
            case (rt)
              mctb_pkg::REQ_TICK: res_status <= 1'b0;
              mctb_pkg::REQ_FREE: begin
                if (ridx_ok) begin
                  alloc[ridx]   <= 1'b0;
                  running[ridx] <= 1'b0;
                  res_status    <= 1'b0;
                  res_index     <= req.timer_index;
                end
              end
              mctb_pkg::REQ_SET_RELOAD: begin
                if (ridx_alloc) begin
                  rld_vld[ridx] <= 1'b1;
                  res_status    <= 1'b0;
                  res_index     <= req.timer_index;
                end
              end
              mctb_pkg::REQ_START_PER,
              mctb_pkg::REQ_START_ONE: begin
                if (ridx_alloc) begin
                  running[ridx]  <= 1'b1;
                  one_shot[ridx] <= (rt == mctb_pkg::REQ_START_ONE);
                  res_status     <= 1'b0;
                  res_index      <= req.timer_index;
                end
              end
              mctb_pkg::REQ_STOP: begin
                if (ridx_alloc) begin
                  running[ridx] <= 1'b0;
                  res_status    <= 1'b0;
                  res_index     <= req.timer_index;
                end
              end
              default: ;
            endcase
          end
        end
        mctb_pkg::ST_ALLOC: begin
          // Scan for the lowest free timer
          if (!alloc[ptr_i]) begin
            alloc[ptr_i] <= 1'b1;
            res_status   <= 1'b0;
            res_index    <= mctb_pkg::IDX_W'(ptr_i);
          end else if (ptr != PTR_LAST) begin
            ptr <= ptr + CW'(1);
          end
        end
        mctb_pkg::ST_TICK: begin
          if (tick_issue) begin
            ptr <= ptr + CW'(1);
          end
          if (tick_hit) begin
            if (one_shot[proc_idx]) begin
              running[proc_idx] <= 1'b0;
            end
            for (int b = 0; b < mctb_pkg::MASK_W; b++) begin
              if (int'(proc_idx) == b) begin
                mask_q[b] <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_word.status       = res_status;
  assign res_word.result_index = res_index;
  assign res_word.expired_mask = mask_q;

  mctb_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (res_word),
    .free (out_free),
    .rsp  (rsp)
  );

  // A running timer is always an allocated one
  assert property (@(posedge clk) disable iff (rst) (running & ~alloc) == '0)
    else $error("timer running without allocation");
  // An accepted word always starts work
  assert property (@(posedge clk) disable iff (rst)
    acc |=> state != mctb_pkg::ST_IDLE)
    else $error("accepted word left the sequencer idle");
  // Counter write-back only follows a read issued by the tick walk
  assert property (@(posedge clk) disable iff (rst)
    proc_vld |-> $past(state) == mctb_pkg::ST_TICK)
    else $error("tick write-back without a walk read");
  // Start write needs the reload read issued from idle
  assert property (@(posedge clk) disable iff (rst)
    state == mctb_pkg::ST_START |-> $past(state) == mctb_pkg::ST_IDLE)
    else $error("start write without reload read");

endmodule
